// ===== rtl/core/rrht_pkg.sv =====
// Shared widths and control types for the rounded-rectangle hit test core.
`default_nettype none
package rrht_pkg;

  // Coordinate width (Q11.4 at 16 bits); radii are one bit narrower.
  localparam int COORD_BITS = 16;
  localparam int RAD_BITS   = COORD_BITS - 1;
  // Headroom for sums of two coordinates and their doubles.
  localparam int EXT_BITS   = COORD_BITS + 2;
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int PROD_BITS  = 2 * SQ_BITS;

  // Stream payload packing.
  localparam int IN_FIELDS_BITS = 6 * COORD_BITS + 2 * RAD_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELDS_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = 8;

  // Stage load enables for the ellipse arithmetic.
  typedef struct packed {
    logic sq_en;    // square stage
    logic prod_en;  // cross-product stage
  } rrht_ell_en_t;

endpackage
`default_nettype wire

// ===== rtl/core/rrht_ellipse.sv =====
// Two-stage ellipse arithmetic: squares, cross products, strict compare.
`default_nettype none
module rrht_ellipse
  import rrht_pkg::*;
(
  input  wire logic                clk,
  input  wire rrht_ell_en_t        en,
  input  wire logic [RAD_BITS-1:0] adx,
  input  wire logic [RAD_BITS-1:0] ady,
  input  wire logic [RAD_BITS-1:0] rad_x,
  input  wire logic [RAD_BITS-1:0] rad_y,
  output logic                     ell_lt
);

  logic [SQ_BITS-1:0]   dx2_r, dy2_r, rx2_r, ry2_r;
  logic [PROD_BITS-1:0] a_r, b_r, c_r;
  logic [PROD_BITS:0]   lhs;

  always_ff @(posedge clk) begin
    if (en.sq_en) begin
      dx2_r <= adx * adx;
      dy2_r <= ady * ady;
      rx2_r <= rad_x * rad_x;
      ry2_r <= rad_y * rad_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod_en) begin
      a_r <= dx2_r * ry2_r;
      b_r <= dy2_r * rx2_r;
      c_r <= rx2_r * ry2_r;
    end
  end

  // dx^2 ry^2 + dy^2 rx^2 < rx^2 ry^2
  assign lhs    = {1'b0, a_r} + {1'b0, b_r};
  assign ell_lt = lhs < {1'b0, c_r};

endmodule
`default_nettype wire

// ===== rtl/core/rounded_rect_hit_test_core.sv =====
// Top level of the rounded-rectangle hit test pipeline.
//
// Usage: each transfer on the in_ stream carries one point, the rectangle
// minimum and maximum corners and the two corner radii; each transfer on
// the out_ stream carries one bit, set when the point lies strictly inside
// the rounded rectangle. Results leave in the order items arrive, one per item.
//
// Throughput: one item per cycle while the receiver keeps out_tready high,
// through the five-stage pipeline (rectangle compares, corner box and
// offsets, squares, cross products, final compare into the output register);
// every stage takes a new item each cycle unless back-pressure holds it.
//
// Reset (rst_n low, synchronous) clears all stage valid bits; payload
// registers are not reset. When the receiver holds out_tready low, only the
// full stages behind the waiting result hold; empty stages keep filling, so
// in_tready stays high until the pipeline is full. Nothing is lost or repeated.
`default_nettype none
module rounded_rect_hit_test_core
  import rrht_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // from bit 0: point_x, point_y, left_x, top_y, right_x, bottom_y,
  // radius_x, radius_y, zero pad
  input  wire logic [IN_DATA_BITS-1:0] in_tdata,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // from bit 0: inside_res, zero pad
  output logic [OUT_DATA_BITS-1:0]     out_tdata
);

  localparam int CB = COORD_BITS;

  // ---- field unpack ----
  logic signed [CB-1:0] px_in, py_in, lx_in, ty_in, rxp_in, by_in;
  logic [RAD_BITS-1:0]  rx_in, ry_in;

  assign px_in  = in_tdata[0*CB +: CB];
  assign py_in  = in_tdata[1*CB +: CB];
  assign lx_in  = in_tdata[2*CB +: CB];
  assign ty_in  = in_tdata[3*CB +: CB];
  assign rxp_in = in_tdata[4*CB +: CB];
  assign by_in  = in_tdata[5*CB +: CB];
  assign rx_in  = in_tdata[6*CB +: RAD_BITS];
  assign ry_in  = in_tdata[6*CB + RAD_BITS +: RAD_BITS];

  // ---- stage enables: a stage loads when empty or when it drains ----
  logic v1_r, v2_r, v3_r, v4_r, out_tvalid_r;
  logic en1, en2, en3, en4, en5;

  assign en5       = !out_tvalid_r || out_tready;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) out_tvalid_r <= v4_r;
    end
  end

  // ---- stage 1: rectangle test, narrow test, quadrant, ellipse centre ----
  logic signed [EXT_BITS-1:0] px_e, py_e, lx_e, ty_e, rxp_e, by_e, rx_e, ry_e;
  logic signed [EXT_BITS-1:0] wid, hgt, cx_l, cx_r, cy_t, cy_b;
  logic                       in_rect, narrow, left, top;

  assign px_e  = EXT_BITS'(px_in);
  assign py_e  = EXT_BITS'(py_in);
  assign lx_e  = EXT_BITS'(lx_in);
  assign ty_e  = EXT_BITS'(ty_in);
  assign rxp_e = EXT_BITS'(rxp_in);
  assign by_e  = EXT_BITS'(by_in);
  assign rx_e  = signed'({{(EXT_BITS-RAD_BITS){1'b0}}, rx_in});
  assign ry_e  = signed'({{(EXT_BITS-RAD_BITS){1'b0}}, ry_in});

  assign in_rect = (px_e > lx_e) && (py_e > ty_e) && (px_e < rxp_e) && (py_e < by_e);
  assign wid     = rxp_e - lx_e;
  assign hgt     = by_e - ty_e;
  assign narrow  = (wid < (rx_e + rx_e)) || (hgt < (ry_e + ry_e));
  // midpoint ties go right / bottom
  assign left    = (px_e + px_e) < (lx_e + rxp_e);
  assign top     = (py_e + py_e) < (ty_e + by_e);
  assign cx_l    = lx_e + rx_e;
  assign cx_r    = rxp_e - rx_e;
  assign cy_t    = ty_e + ry_e;
  assign cy_b    = by_e - ry_e;

  logic                       plain1_r, narrow1_r, left1_r, top1_r;
  logic signed [EXT_BITS-1:0] px1_r, py1_r, cx1_r, cy1_r;
  logic [RAD_BITS-1:0]        rx1_r, ry1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      plain1_r  <= in_rect;
      narrow1_r <= narrow;
      left1_r   <= left;
      top1_r    <= top;
      px1_r     <= px_e;
      py1_r     <= py_e;
      cx1_r     <= left ? cx_l : cx_r;
      cy1_r     <= top ? cy_t : cy_b;
      rx1_r     <= rx_in;
      ry1_r     <= ry_in;
    end
  end

  // ---- stage 2: corner box test and offset magnitudes ----
  logic                       in_bx, in_by, need2;
  logic signed [EXT_BITS-1:0] magx, magy;

  assign in_bx = left1_r ? (px1_r < cx1_r) : (px1_r > cx1_r);
  assign in_by = top1_r ? (py1_r < cy1_r) : (py1_r > cy1_r);
  // inside the box the offset is below the radius, so the low bits suffice
  assign magx  = left1_r ? (cx1_r - px1_r) : (px1_r - cx1_r);
  assign magy  = top1_r ? (cy1_r - py1_r) : (py1_r - cy1_r);
  assign need2 = plain1_r && !narrow1_r && in_bx && in_by;

  logic                plain2_r, need2_r;
  logic [RAD_BITS-1:0] adx2_r, ady2_r, rx2_r, ry2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      plain2_r <= plain1_r;
      need2_r  <= need2;
      adx2_r   <= magx[RAD_BITS-1:0];
      ady2_r   <= magy[RAD_BITS-1:0];
      rx2_r    <= rx1_r;
      ry2_r    <= ry1_r;
    end
  end

  // ---- stages 3 and 4: ellipse arithmetic ----
  rrht_ell_en_t ell_en;
  logic         ell_lt;

  assign ell_en.sq_en   = en3;
  assign ell_en.prod_en = en4;

  rrht_ellipse u_ellipse (
    .clk    (clk),
    .en     (ell_en),
    .adx    (adx2_r),
    .ady    (ady2_r),
    .rad_x  (rx2_r),
    .rad_y  (ry2_r),
    .ell_lt (ell_lt)
  );

  logic plain3_r, need3_r, plain4_r, need4_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      plain3_r <= plain2_r;
      need3_r  <= need2_r;
    end
    if (en4) begin
      plain4_r <= plain3_r;
      need4_r  <= need3_r;
    end
  end

  // ---- stage 5: output register ----
  logic inside_r;

  always_ff @(posedge clk) begin
    if (en5) inside_r <= need4_r ? ell_lt : plain4_r;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-1){1'b0}}, inside_r};

  // ---- assertions ----
  a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(v4_r))
    else $error("result appeared without an item in the last stage");

  a_ell_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && need4_r) |-> plain4_r)
    else $error("ellipse path taken for a point outside the rectangle");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en5 && v4_r && !need4_r) |=> (out_tdata[0] == $past(plain4_r)))
    else $error("plain rectangle result not carried to the output");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted item not held in the first stage");

endmodule
`default_nettype wire

// ===== tb/rrht_hit_checker.sv =====
// Hit-test checker: predicts inside_res for each query transfer and compares it with the result.
`timescale 1ns / 1ps
module rrht_hit_checker
  import rrht_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,
  output int                       fail_count,
  output int                       pending,
  output int                       n_checked,
  output int                       n_hits
);

  typedef struct {
    bit                      hit;
    logic [IN_DATA_BITS-1:0] query;
  } hit_exp_t;

  hit_exp_t pending_hits[$];
  int       fails   = 0;
  int       checked = 0;
  int       hits    = 0;

  function automatic longint coord_at(logic [IN_DATA_BITS-1:0] d, int idx);
    logic signed [COORD_BITS-1:0] c;
    c = d[idx*COORD_BITS +: COORD_BITS];
    return longint'(c);
  endfunction

  // Strict inside test of the rounded rectangle; the corner ellipse is
  // compared exactly in 128-bit integers.
  function automatic bit predict_inside(logic [IN_DATA_BITS-1:0] d);
    longint     px, py, lx, ty, rgt, bot, radx, rady, cx, cy, adx, ady;
    bit         is_left, is_top, in_box;
    logic [127:0] dx2, dy2, rx2, ry2;
    px   = coord_at(d, 0);
    py   = coord_at(d, 1);
    lx   = coord_at(d, 2);
    ty   = coord_at(d, 3);
    rgt  = coord_at(d, 4);
    bot  = coord_at(d, 5);
    radx = longint'(d[6*COORD_BITS +: RAD_BITS]);
    rady = longint'(d[6*COORD_BITS+RAD_BITS +: RAD_BITS]);
    if (!(px > lx && py > ty && px < rgt && py < bot)) return 1'b0;
    // too narrow or short for the corners: plain rectangle decides
    if ((rgt - lx) < 2 * radx || (bot - ty) < 2 * rady) return 1'b1;
    // ties on the midpoint go right / bottom
    is_left = (2 * px < lx + rgt);
    is_top  = (2 * py < ty + bot);
    cx      = is_left ? lx + radx : rgt - radx;
    cy      = is_top  ? ty + rady : bot - rady;
    in_box  = (is_left ? px < cx : px > cx) && (is_top ? py < cy : py > cy);
    if (!in_box) return 1'b1;
    adx = (px < cx) ? cx - px : px - cx;
    ady = (py < cy) ? cy - py : py - cy;
    dx2 = adx * adx;
    dy2 = ady * ady;
    rx2 = radx * radx;
    ry2 = rady * rady;
    return (dx2 * ry2 + dy2 * rx2) < (rx2 * ry2);
  endfunction

  // one line per mismatch
  task automatic report_mismatch(string what, hit_exp_t e, logic [OUT_DATA_BITS-1:0] got);
    fails++;
    $display("%0t: hit check: %s; query %h expected %0b got %h",
             $time, what, e.query, e.hit, got);
  endtask

  always @(posedge clk) begin
    hit_exp_t                 e;
    logic [OUT_DATA_BITS-1:0] got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        e.query = in_tdata;
        e.hit   = predict_inside(in_tdata);
        pending_hits.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_hits.size() == 0) begin
          e.query = '0;
          e.hit   = 1'b0;
          report_mismatch("result with no query outstanding", e, got);
        end else begin
          e = pending_hits.pop_front();
          checked++;
          if (got[0] !== e.hit)
            report_mismatch("inside_res wrong", e, got);
          else if (got[OUT_DATA_BITS-1:1] !== '0)
            report_mismatch("pad bits not zero", e, got);
          if (got[0] === 1'b1) hits++;
        end
      end
    end
    fail_count <= fails;
    pending    <= pending_hits.size();
    n_checked  <= checked;
    n_hits     <= hits;
  end

endmodule

// ===== tb/tb_rounded_rect_hit_test_core.sv =====
// Testbench top for the rounded-rectangle hit test core: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_rounded_rect_hit_test_core;
  import rrht_pkg::*;

  localparam int N_RANDOM = 1000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  // from bit 0: point_x, point_y, left_x, top_y, right_x, bottom_y,
  // radius_x, radius_y, zero pad
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  // from bit 0: inside_res, zero pad
  logic [OUT_DATA_BITS-1:0] out_tdata;

  int fail_count, pending, n_checked, n_hits;
  int n_sent     = 0;
  int n_directed = 0;
  // quiet stretches: neither side idles while this is set
  bit quiet      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rounded_rect_hit_test_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rrht_hit_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_hits     (n_hits)
  );

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Coordinates are raw Q11.4 counts; radii keep their low RAD_BITS bits.
  function automatic logic [IN_DATA_BITS-1:0] pack_query(int px, int py, int lx, int ty,
                                                         int rgt, int bot, int radx, int rady);
    logic [IN_DATA_BITS-1:0] d;
    d = '0;
    d[0*COORD_BITS +: COORD_BITS]          = px[COORD_BITS-1:0];
    d[1*COORD_BITS +: COORD_BITS]          = py[COORD_BITS-1:0];
    d[2*COORD_BITS +: COORD_BITS]          = lx[COORD_BITS-1:0];
    d[3*COORD_BITS +: COORD_BITS]          = ty[COORD_BITS-1:0];
    d[4*COORD_BITS +: COORD_BITS]          = rgt[COORD_BITS-1:0];
    d[5*COORD_BITS +: COORD_BITS]          = bot[COORD_BITS-1:0];
    d[6*COORD_BITS +: RAD_BITS]            = radx[RAD_BITS-1:0];
    d[6*COORD_BITS+RAD_BITS +: RAD_BITS]   = rady[RAD_BITS-1:0];
    return d;
  endfunction

  // Holds the query until it is taken. in_tvalid only drops when a gap
  // is wanted, so back-to-back transfers never see a low/high pair.
  task automatic send_query(logic [IN_DATA_BITS-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  // Well-formed query: a real rectangle, radii mostly fitting, point mostly
  // pushed into a corner box so the ellipse compare is exercised.
  task automatic send_shaped_query();
    int w, h, lx, ty, radx, rady, px, py;
    w  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 400);
    h  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 400);
    lx = int'($urandom_range(0, 65535 - w)) - 32768;
    ty = int'($urandom_range(0, 65535 - h)) - 32768;
    radx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, w / 2) : $urandom_range(0, 32767);
    rady = ($urandom_range(0, 9) < 7) ? $urandom_range(0, h / 2) : $urandom_range(0, 32767);
    if ($urandom_range(0, 9) < 6) begin
      px = $urandom_range(0, 1) ? lx + int'($urandom_range(0, radx + 1))
                                : lx + w - int'($urandom_range(0, radx + 1));
      py = $urandom_range(0, 1) ? ty + int'($urandom_range(0, rady + 1))
                                : ty + h - int'($urandom_range(0, rady + 1));
    end else begin
      px = lx - 2 + int'($urandom_range(0, w + 4));
      py = ty - 2 + int'($urandom_range(0, h + 4));
    end
    send_query(pack_query(clamp16(px), clamp16(py), lx, ty, lx + w, ty + h, radx, rady));
  endtask

  // Result side back-pressure: random stalls between ready runs.
  initial begin
    int gap;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Generous ceiling: well over a thousand queries each waiting out the
  // longest source gap and the longest sink stall.
  initial begin
    #(5_000_000);
    $display("** rounded_rect_hit_test_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Units are raw Q11.4 counts (16 = 1.0).
    // all zero: empty rectangle
    send_query(pack_query(0, 0, 0, 0, 0, 0, 0, 0));
    // full-range rectangle, square corners
    send_query(pack_query(0, 0, -32768, -32768, 32767, 32767, 0, 0));
    // points on the extreme edges are not strictly inside
    send_query(pack_query(-32768, 0, -32768, -32768, 32767, 32767, 0, 0));
    send_query(pack_query(32767, 32767, -32768, -32768, 32767, 32767, 0, 0));
    // inverted and zero-width rectangles
    send_query(pack_query(0, 0, 100, -100, -100, 100, 5, 5));
    send_query(pack_query(50, 50, 50, 0, 50, 100, 0, 0));
    // zero radius: tip of the corner is inside
    send_query(pack_query(1, 1, 0, 0, 100, 100, 0, 0));
    // largest radii over the full range: huge products
    send_query(pack_query(-32767, -32767, -32768, -32768, 32767, 32767, 32767, 32767));
    send_query(pack_query(0, 0, -32768, -32768, 32767, 32767, 32767, 32767));
    send_query(pack_query(32766, -32767, -32768, -32768, 32767, 32767, 32767, 32767));
    // radius wider than half the rectangle: plain test decides
    send_query(pack_query(1, 1, 0, 0, 100, 100, 51, 5));
    send_query(pack_query(1, 1, 0, 0, 100, 100, 5, 51));
    // top-left corner, r = 5: on the ellipse, inside it, outside it
    send_query(pack_query(2, 1, 0, 0, 100, 100, 5, 5));
    send_query(pack_query(2, 2, 0, 0, 100, 100, 5, 5));
    send_query(pack_query(1, 1, 0, 0, 100, 100, 5, 5));
    // on the edge of the corner box: counts as inside
    send_query(pack_query(5, 1, 0, 0, 100, 100, 5, 5));
    // midpoint ties with radius exactly half the size
    send_query(pack_query(5, 1, 0, 0, 10, 10, 5, 5));
    send_query(pack_query(5, 5, 0, 0, 10, 10, 5, 5));
    send_query(pack_query(1, 1, 0, 0, 10, 10, 5, 5));
    // bottom-right and top-right corners
    send_query(pack_query(98, 99, 0, 0, 100, 100, 5, 5));
    send_query(pack_query(98, 98, 0, 0, 100, 100, 5, 5));
    send_query(pack_query(99, 1, 0, 0, 100, 100, 5, 5));
    // elongated ellipse, and a negative-coordinate rectangle
    send_query(pack_query(4, 2, 0, 0, 200, 50, 20, 4));
    send_query(pack_query(-199, -199, -200, -200, -100, -100, 10, 10));
    // just above the rectangle
    send_query(pack_query(50, -1, 0, 0, 100, 100, 5, 5));
    n_directed = n_sent;

    // Random part: mostly shaped queries, the rest raw noise over all field bits.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 8)
        send_shaped_query();
      else
        send_query(pack_query($urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom));
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    // let the checker count the last transfer, drain, then allow for the pipeline depth
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d hit queries (%0d directed, rest random) with random idling on both sides.",
             n_sent, n_directed);
    $display("Checked %0d results, %0d of them inside.", n_checked, n_hits);
    if (fail_count == 0) begin
      $display("** rounded_rect_hit_test_core: PASSED **");
    end else begin
      $display("** rounded_rect_hit_test_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rrht_pkg.sv
rtl/core/rrht_ellipse.sv
rtl/core/rounded_rect_hit_test_core.sv
tb/rrht_hit_checker.sv
tb/tb_rounded_rect_hit_test_core.sv
